/* rtl/cngh_pkg.sv */
`timescale 1ns / 1ps

package cngh_pkg;

    // Window and field widths.
    localparam int MAX_WINDOW   = 8;
    localparam int WIN_IDX_W    = $clog2(MAX_WINDOW);
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 4;
    localparam int BUCKET_W     = 17;
    localparam int INDEX_W      = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_PAD_W    = OUT_TDATA_W - INDEX_W - 1 - LEN_W;

    // Bucket count limit used when the register holds zero or too large a value.
    localparam int BUCKET_LIMIT = 65536;

    // Hash arithmetic: the base-31 sum of eight bytes fits in 43 bits, and
    // the running power of 31 (up to 31 to the eighth) fits in 40 bits.
    localparam int BASE_INDEX   = 31;
    localparam int HASH_W       = 43;
    localparam int POW_W        = 40;

    // Remainder unit: a few quotient bits per cycle.
    localparam int RADIX_BITS   = 4;
    localparam int DIV_W        = ((HASH_W + RADIX_BITS - 1) / RADIX_BITS) * RADIX_BITS;
    localparam int DIV_STEPS    = DIV_W / RADIX_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BUCKET_W;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS = 2'd2;

    localparam logic [LEN_W-1:0]    MIN_LEN_RESET = 4'd2;
    localparam logic [LEN_W-1:0]    MAX_LEN_RESET = 4'd5;
    localparam logic [BUCKET_W-1:0] BUCKETS_RESET = 17'd4096;

    // Controls for the shared hash accumulator.
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic add_en;
    } hash_ctrl_t;

endpackage

/* rtl/cngh_hash_unit.sv */
`timescale 1ns / 1ps

// Shared multiply-accumulate unit that builds the base-31 hash one byte at a
// time, oldest byte weighted highest, plus the parity of the base-131 hash.
module cngh_hash_unit
    import cngh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  hash_ctrl_t        ctrl,
    input  logic [BYTE_W-1:0] byte_in,
    output logic [HASH_W-1:0] hash,
    output logic              parity
);

    logic [POW_W-1:0]        pow_reg;
    logic [POW_W-1:0]        pow_next;
    logic [HASH_W-1:0]       acc_reg;
    logic [HASH_W-1:0]       prod_reg;
    logic                    par_reg;
    logic [BYTE_W+POW_W-1:0] prod_full;

    // Byte times the current power of 31, then the next power.
    assign prod_full = byte_in * pow_reg;
    assign pow_next  = pow_reg * POW_W'(BASE_INDEX);

    // The product is registered before it is added in.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_full[HASH_W-1:0];
        end
    end

    // Accumulator, power and parity.  Since 131 is odd, the parity of the
    // base-131 hash is the XOR of the bytes' low bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pow_reg <= POW_W'(1);
            acc_reg <= '0;
            par_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            pow_reg <= POW_W'(1);
            acc_reg <= '0;
            par_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.mul_en)
            begin
                par_reg <= par_reg ^ byte_in[0];
            end
            if (ctrl.add_en)
            begin
                acc_reg <= acc_reg + prod_reg;
                pow_reg <= pow_next;
            end
        end
    end

    assign hash   = acc_reg;
    assign parity = par_reg;

endmodule

/* rtl/cngh_mod_unit.sv */
`timescale 1ns / 1ps

// Restoring remainder unit: RADIX_BITS dividend bits per cycle, MSB first.
module cngh_mod_unit
    import cngh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [HASH_W-1:0]   dividend,
    input  logic [BUCKET_W-1:0] divisor,
    output logic                done,
    output logic [INDEX_W-1:0]  remainder
);

    logic [DIV_W-1:0]     shift_reg;
    logic [DIV_W-1:0]     shift_step;
    logic [BUCKET_W-1:0]  rem_reg;
    logic [BUCKET_W-1:0]  rem_step;
    logic [BUCKET_W:0]    trial;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // Several shift-compare-subtract steps; the partial remainder stays below
    // the divisor, so each trial value stays below twice the divisor.
    always_comb
    begin
        rem_step   = rem_reg;
        shift_step = shift_reg;
        trial      = '0;
        for (int j = 0; j < RADIX_BITS; j++)
        begin
            trial      = {rem_step, shift_step[DIV_W-1]};
            shift_step = shift_step << 1;
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_step = trial[BUCKET_W-1:0];
        end
    end

    // Dividend and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= DIV_W'(dividend);
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_step;
            rem_reg   <= rem_step;
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg[INDEX_W-1:0];

endmodule

/* rtl/char_ngram_feature_hasher.sv */
`timescale 1ns / 1ps

// Channel   Dir  Word                                              Marker
// s_axis    in   tdata[7:0] char_code                              tlast = last_char
// m_axis    out  tdata[15:0] bucket_index, [16] sign_negative,     tlast = last_of_run
//                [20:17] gram_length, [23:21] zero
// cfg       in   cfg_we, cfg_index (0 min, 1 max, 2 buckets), cfg_data
//
// Each n-gram length is stepped through a multiply state and an add state in
// the shared multiply-accumulate unit; each result then takes a load, 11 steps
// in the remainder unit (4 bits a cycle over a 44-bit dividend) and its done
// flag, then is handed to the output register. The remainder unit sets the
// rate at which words are taken. One byte is worked on at a time; the next
// word is taken while the final result still waits in the output register.
// A stalled output holds the sequencer at its next result. Reset is
// asynchronous and leaves the window full of spaces and the registers at
// their defaults.
module char_ngram_feature_hasher
    import cngh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] char_code
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // bucket_index, sign_negative, gram_length
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [LEN_W-1:0]    min_len_reg;
    logic [LEN_W-1:0]    max_len_reg;
    logic [BUCKET_W-1:0] buckets_reg;

    logic [LEN_W-1:0]    lo_eff;
    logic [LEN_W-1:0]    hi_eff;
    logic [BUCKET_W-1:0] div_eff;
    logic                gram_empty;

    logic [2:0]          state_reg,  state_next;
    logic [LEN_W-1:0]    lo_reg,     lo_next;
    logic [LEN_W-1:0]    hi_reg,     hi_next;
    logic [BUCKET_W-1:0] div_reg,    div_next;
    logic                last_reg,   last_next;
    logic [LEN_W-1:0]    n_reg,      n_next;
    logic [LEN_W-1:0]    k_reg,      k_next;

    logic [BYTE_W-1:0]   win_reg [MAX_WINDOW];
    logic                win_shift_en;
    logic                win_fill_pad;
    logic [BYTE_W-1:0]   win_byte;
    logic [LEN_W-1:0]    n_minus1;
    logic [WIN_IDX_W-1:0] win_idx;

    hash_ctrl_t          hash_ctrl;
    logic [HASH_W-1:0]   hash;
    logic                parity;
    logic                mod_start;
    logic                mod_done;
    logic [INDEX_W-1:0]  remainder;

    logic                out_load;
    logic                out_last;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_sign_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
            buckets_reg <= BUCKETS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LEN: min_len_reg <= cfg_data[LEN_W-1:0];
                REG_MAX_LEN: max_len_reg <= cfg_data[LEN_W-1:0];
                REG_BUCKETS: buckets_reg <= cfg_data[BUCKET_W-1:0];
                default:     ;
            endcase
        end
    end

    // Effective length range and divisor after clamping.
    assign lo_eff     = (min_len_reg == '0) ? LEN_W'(1) : min_len_reg;
    assign hi_eff     = (max_len_reg > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) : max_len_reg;
    assign div_eff    = (buckets_reg == '0 || buckets_reg > BUCKET_W'(BUCKET_LIMIT))
                        ? BUCKET_W'(BUCKET_LIMIT) : buckets_reg;
    assign gram_empty = lo_eff > hi_eff;

    // The result ending a pass is the last of the run unless more trailing
    // padded passes follow.
    assign out_last = (n_reg == hi_reg) && (!last_reg || k_reg == hi_reg - LEN_W'(1));

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        div_next     = div_reg;
        last_next    = last_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        hash_ctrl    = '0;
        mod_start    = 1'b0;
        win_shift_en = 1'b0;
        win_fill_pad = 1'b0;
        win_byte     = PAD_BYTE;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    lo_next         = lo_eff;
                    hi_next         = hi_eff;
                    div_next        = div_eff;
                    last_next       = s_axis_tlast;
                    n_next          = LEN_W'(1);
                    k_next          = '0;
                    hash_ctrl.clear = 1'b1;
                    if (gram_empty && s_axis_tlast)
                    begin
                        win_fill_pad = 1'b1;
                    end
                    else
                    begin
                        win_shift_en = 1'b1;
                        win_byte     = s_axis_tdata;
                    end
                    if (!gram_empty)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                hash_ctrl.mul_en = 1'b1;
                state_next       = ST_ADD;
            end
            ST_ADD:
            begin
                hash_ctrl.add_en = 1'b1;
                if (n_reg > k_reg && n_reg >= lo_reg)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    n_next     = n_reg + LEN_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_LOAD:
            begin
                mod_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load = 1'b1;
                    if (n_reg == hi_reg)
                    begin
                        if (last_reg && k_reg < hi_reg - LEN_W'(1))
                        begin
                            // Shift in one more trailing space and start over.
                            win_shift_en    = 1'b1;
                            k_next          = k_reg + LEN_W'(1);
                            n_next          = LEN_W'(1);
                            hash_ctrl.clear = 1'b1;
                            state_next      = ST_MUL;
                        end
                        else
                        begin
                            win_fill_pad = last_reg;
                            state_next   = ST_IDLE;
                        end
                    end
                    else
                    begin
                        n_next     = n_reg + LEN_W'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lo_reg    <= '0;
            hi_reg    <= '0;
            div_reg   <= '0;
            last_reg  <= 1'b0;
            n_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            div_reg   <= div_next;
            last_reg  <= last_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    // Byte window, newest byte in entry zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                win_reg[i] <= PAD_BYTE;
            end
        end
        else if (win_fill_pad)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                win_reg[i] <= PAD_BYTE;
            end
        end
        else if (win_shift_en)
        begin
            for (int i = MAX_WINDOW - 1; i > 0; i--)
            begin
                win_reg[i] <= win_reg[i-1];
            end
            win_reg[0] <= win_byte;
        end
    end

    assign n_minus1 = n_reg - LEN_W'(1);
    assign win_idx  = n_minus1[WIN_IDX_W-1:0];

    cngh_hash_unit u_hash
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (hash_ctrl),
        .byte_in (win_reg[win_idx]),
        .hash    (hash),
        .parity  (parity)
    );

    cngh_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (hash),
        .divisor   (div_reg),
        .done      (mod_done),
        .remainder (remainder)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg <= remainder;
            out_sign_reg  <= parity;
            out_len_reg   <= n_reg;
            out_last_reg  <= out_last;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {OUT_PAD_W'(0), out_len_reg, out_sign_reg, out_index_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

/* rtl/cngh_checker.sv */
`timescale 1ns / 1ps

// Port-level checks for the n-gram hasher.
module cngh_checker
    import cngh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic [LEN_W-1:0] out_len;

    assign out_len = m_axis_tdata[INDEX_W+1 +: LEN_W];

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Every result carries a length within the window.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_len >= LEN_W'(1) && out_len <= LEN_W'(MAX_WINDOW)))
        else $error("gram length out of range");

    // The input side only goes busy after taking a word.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input went busy without an accepted word");

    // No result is offered on the edge after reset is seen.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind char_ngram_feature_hasher cngh_checker u_cngh_checker (.*);
